/* src/wbps_pkg.sv */
package wbps_pkg;

    // fixed field widths of the stream items
    localparam int BYTE_W     = 8;
    localparam int INDEX_W    = 7;
    localparam int LENGTH_W   = 8;
    localparam int OFFSET_W   = 32;
    // pattern positions a load item can address
    localparam int LOADABLE_DEPTH = 2 ** INDEX_W;

    // input item commands
    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_SCAN    = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_e;

    // configuration register indexes
    localparam logic CFG_PATTERN_LENGTH = 1'b0;
    localparam logic CFG_REPORT_ALL     = 1'b1;

    // configuration reset values
    localparam logic [LENGTH_W-1:0] PATTERN_LENGTH_RESET = 8'd1;
    localparam logic                REPORT_ALL_RESET     = 1'b1;

    // one input item
    typedef struct packed {
        logic [1:0]         cmd;
        logic [BYTE_W-1:0]  data_byte;
        logic               care;
        logic [INDEX_W-1:0] pattern_index;
        logic               end_of_data;
    } item_t;

    // per-item strobes, high in the cycle the item is processed
    typedef struct packed {
        logic load;
        logic scan;
        logic restart;
    } step_t;

    // one result item
    typedef struct packed {
        logic                valid;
        logic                matched;
        logic [OFFSET_W-1:0] match_offset;
        logic                done_res;
        logic                any_found;
    } result_t;

endpackage

/* src/wbps_match_cells.sv */
module wbps_match_cells #(
    parameter int MAX_PATTERN_LEN = 128,
    parameter int LEN_W           = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wbps_pkg::step_t               step,
    input  wbps_pkg::item_t               item,
    input  logic [LEN_W-1:0]              len_eff,
    output logic                          hit
);

    logic [MAX_PATTERN_LEN-1:0] prog_reg;
    logic [MAX_PATTERN_LEN-1:0] prog_next;
    logic [MAX_PATTERN_LEN-1:0] last_mask;

    // one cell per pattern position: stored entry, compare, shift-and update
    for (genvar j = 0; j < MAX_PATTERN_LEN; j++) begin : g_pos
        logic [wbps_pkg::BYTE_W-1:0] pat_byte;
        logic                        pat_care;
        logic                        eq;
        logic                        prev;

        if (j < wbps_pkg::LOADABLE_DEPTH) begin : g_store
            logic [wbps_pkg::BYTE_W-1:0] pat_byte_reg;
            logic                        pat_care_reg;

            // pattern entry write on a load transfer
            always_ff @(posedge clk)
            begin
                if (step.load && (item.pattern_index == wbps_pkg::INDEX_W'(j)))
                begin
                    pat_byte_reg <= item.data_byte;
                    pat_care_reg <= item.care;
                end
            end

            assign pat_byte = pat_byte_reg;
            assign pat_care = pat_care_reg;
        end
        else begin : g_unreachable
            // positions no load can address read as a wildcard
            assign pat_byte = '0;
            assign pat_care = 1'b0;
        end

        if (j == 0) begin : g_first
            assign prev = 1'b1;
        end
        else begin : g_rest
            assign prev = prog_reg[j-1];
        end

        assign eq = !pat_care || (pat_byte == item.data_byte);
        assign prog_next[j] = (LEN_W'(j) < len_eff) && prev && eq;
        assign last_mask[j] = (LEN_W'(j + 1) == len_eff);
    end

    // a match ends here when the last active position lights up
    assign hit = |(prog_next & last_mask);

    // partial match vector
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_reg <= '0;
        end
        else if (step.restart)
        begin
            prog_reg <= '0;
        end
        else if (step.scan)
        begin
            prog_reg <= prog_next;
        end
    end

endmodule

/* src/wbps_scan_ctrl.sv */
module wbps_scan_ctrl #(
    parameter int LEN_W = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wbps_pkg::step_t      step,
    input  logic                 end_of_data,
    input  logic                 hit,
    input  logic [LEN_W-1:0]     len_eff,
    input  logic                 report_all,
    output wbps_pkg::result_t    result
);

    logic [wbps_pkg::OFFSET_W-1:0] pos_reg;
    logic [wbps_pkg::OFFSET_W-1:0] pos_next;
    logic                          found_reg;
    logic                          found_next;
    logic                          report;
    logic [wbps_pkg::OFFSET_W-1:0] start;

    // report decision and start offset of the match
    always_comb
    begin
        report = step.scan && hit && (report_all || !found_reg);
        start  = pos_reg - (wbps_pkg::OFFSET_W'(len_eff) - wbps_pkg::OFFSET_W'(1));
    end

    // offset counter and found flag
    always_comb
    begin
        pos_next   = pos_reg;
        found_next = found_reg;
        if (step.restart)
        begin
            pos_next   = '0;
            found_next = 1'b0;
        end
        else if (step.scan)
        begin
            pos_next   = pos_reg + wbps_pkg::OFFSET_W'(1);
            found_next = found_reg || report;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            found_reg <= found_next;
        end
    end

    // result fields, valid on a report or on a scan item that ends the data
    always_comb
    begin
        result.valid        = step.scan && (report || end_of_data);
        result.matched      = report;
        result.match_offset = report ? start : '0;
        result.done_res     = end_of_data;
        result.any_found    = found_reg || report;
    end

endmodule

/* src/wildcard_byte_pattern_search_unit.sv */
// Wildcard byte pattern search. Load transfers (tuser = load) write pattern
// positions of a byte and a care bit, care 0 being a wildcard; scan transfers
// feed one stream byte each, with tlast on the last byte of the data; a restart
// transfer clears the partial matches, the offset counter and the found flag
// but keeps the pattern. Each reported match gives one result with the 32-bit
// stream offset of its first byte; the last byte of the data always gives a
// result with tlast set and any_found telling whether a match was reported since
// restart. With report_all at 0 only the first match after a restart is
// reported. Each item goes through an input register, one pass through the
// per-position compare cells and the shift-and vector, then the result
// register, so one transfer is taken every clock while the result side keeps
// up. Pattern positions must be loaded before they are used; the user must
// write configuration only while idle, which the block does not enforce.
module wildcard_byte_pattern_search_unit #(
    parameter int MAX_PATTERN_LEN = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte[7:0], care[8], pattern_index[15:9]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    input  logic        s_tlast,   // end_of_data
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // matched[0], match_offset[32:1], any_found[33], zero
    output logic        m_tlast    // done_res
);

    localparam int LEN_W = $clog2(MAX_PATTERN_LEN + 1);
    localparam int CMP_W = (LEN_W > wbps_pkg::LENGTH_W) ? LEN_W : wbps_pkg::LENGTH_W;

    logic [wbps_pkg::LENGTH_W-1:0] len_cfg_reg;
    logic                          report_all_reg;
    logic [LEN_W-1:0]              len_eff;

    logic                          s1_valid_reg;
    wbps_pkg::item_t               s1_item_reg;
    logic                          advance;
    wbps_pkg::step_t               step;
    logic                          hit;
    wbps_pkg::result_t             result;

    logic                          m_valid_reg;
    wbps_pkg::result_t             m_res_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg    <= wbps_pkg::PATTERN_LENGTH_RESET;
            report_all_reg <= wbps_pkg::REPORT_ALL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wbps_pkg::CFG_PATTERN_LENGTH: len_cfg_reg    <= cfg_wdata;
                wbps_pkg::CFG_REPORT_ALL:     report_all_reg <= cfg_wdata[0];
                default:                      len_cfg_reg    <= len_cfg_reg;
            endcase
        end
    end

    // length in use: zero reads as one, saturated at the pattern depth
    always_comb
    begin
        if (len_cfg_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (CMP_W'(len_cfg_reg) > CMP_W'(MAX_PATTERN_LEN))
        begin
            len_eff = LEN_W'(MAX_PATTERN_LEN);
        end
        else
        begin
            len_eff = LEN_W'(len_cfg_reg);
        end
    end

    // handshake: the pipe moves whenever the result register can take a value
    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_item_reg.cmd           <= s_tuser;
            s1_item_reg.data_byte     <= s_tdata[7:0];
            s1_item_reg.care          <= s_tdata[8];
            s1_item_reg.pattern_index <= s_tdata[15:9];
            s1_item_reg.end_of_data   <= s_tlast;
        end
    end

    // command decode for the item being processed
    always_comb
    begin
        step.load    = s1_valid_reg && advance && (s1_item_reg.cmd == wbps_pkg::CMD_LOAD);
        step.scan    = s1_valid_reg && advance && (s1_item_reg.cmd == wbps_pkg::CMD_SCAN);
        step.restart = s1_valid_reg && advance && (s1_item_reg.cmd == wbps_pkg::CMD_RESTART);
    end

    wbps_match_cells #(
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
        .LEN_W           (LEN_W)
    ) u_cells (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .item    (s1_item_reg),
        .len_eff (len_eff),
        .hit     (hit)
    );

    wbps_scan_ctrl #(
        .LEN_W (LEN_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .end_of_data (s1_item_reg.end_of_data),
        .hit         (hit),
        .len_eff     (len_eff),
        .report_all  (report_all_reg),
        .result      (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_valid_reg <= result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.valid)
        begin
            m_res_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_res_reg.any_found, m_res_reg.match_offset, m_res_reg.matched};
    assign m_tlast  = m_res_reg.done_res;

    // a reported match is always counted as found
    a_match_implies_found: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> m_tdata[33])
        else $error("match reported without any_found");

    // no match means the offset field reads zero
    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[32:1] == 32'd0))
        else $error("nonzero offset without a match");

    // every result carries a match or the end of data
    a_result_reason: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] || m_tlast))
        else $error("result with neither match nor end of data");

    // an empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with the result register empty");

endmodule
